// ----- rtl/rfc_pkg.sv -----
// Shared constants, command/status structs and CRC/LFSR step functions
// for the readout fragment checker. No dependencies.
`default_nettype none
package rfc_pkg;

  localparam int unsigned MIN_WORDS            = 2413;
  localparam int unsigned MAX_WORDS            = 2443;
  localparam int unsigned MAX_TRAILER_TRIGGERS = 30;
  localparam int unsigned TRAILER_DEPTH        = 32;
  localparam int unsigned RING_AW              = $clog2(TRAILER_DEPTH);

  localparam logic [31:0] SIG_WORD      = 32'h42534D44;
  localparam logic [31:0] FILLER_WORD   = 32'hDEADFACE;
  localparam logic [31:0] CRC_POLY      = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
  localparam logic [12:0] SANE_TOKEN    = 13'd4097;
  localparam logic [7:0]  DET_ID_EXP    = 8'd5;
  localparam logic [7:0]  NULL_FORMAT   = 8'h02;
  localparam logic [7:0]  FIBER_ANY     = 8'hFF;
  localparam logic [11:0] PATTERN_FIRST = 12'd10;
  localparam logic [11:0] PATTERN_END   = 12'd2410;
  localparam logic [11:0] IDX_MAX       = 12'd4095;
  localparam logic [11:0] IDX_FILLER    = 12'd9;

  // trigger command codes
  localparam logic [3:0] TRG_CLEAR   = 4'd2;
  localparam logic [3:0] TRG_PHYS_A  = 4'd4;
  localparam logic [3:0] TRG_PHYS_B  = 4'd8;
  localparam logic [3:0] TRG_PATTERN = 4'd11;
  localparam logic [3:0] TRG_PHYS_C  = 4'd12;

  // header word positions
  localparam logic [11:0] POS_TOKEN = 12'd0;
  localparam logic [11:0] POS_SIG   = 12'd1;
  localparam logic [11:0] POS_CMD   = 12'd2;
  localparam logic [11:0] POS_STAT  = 12'd3;
  localparam logic [11:0] POS_XING  = 12'd4;

  typedef struct packed {
    logic       accept;     // input word transfer
    logic       crc_step;   // fold one byte into the CRC
    logic [1:0] crc_sel;    // byte 0 = top byte of incoming word
    logic       rd_en;      // ring read at position idx-1-rd_off
    logic [4:0] rd_off;
    logic       latch_ml;
    logic       scan_chk;
    logic       decide;
    logic       load_hdr;
    logic       load_trl;
    logic       trl_last;
    logic       end_frag;
  } dp_cmd_t;

  typedef struct packed {
    logic [4:0] ml;         // trailer trigger count after limit check
    logic       single;     // null or critical: one record only
    logic       out_free;
  } dp_stat_t;

  function automatic logic [31:0] crc_fold8(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int j = 7; j >= 0; j--) begin
      if (r[31] == b[j]) r = {r[30:0], 1'b0} ^ CRC_POLY;
      else r = {r[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    return {s[30:0], ~(s[31] ^ s[21] ^ s[1] ^ s[0])};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rfc_ctrl.sv -----
// Sequencer for the fragment checker: word intake, CRC byte steps,
// trailer scan and record emission. Depends on rfc_pkg.
`default_nettype none
module rfc_ctrl
  import rfc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CRC, S_ML, S_SCAN, S_DECIDE, S_HDR, S_TRL, S_END
  } state_t;

  state_t     state, state_next;
  logic [1:0] step, step_next;
  logic [4:0] j, j_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    j_next     = j;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_last) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_off = 5'd0;
            state_next = S_ML;
          end else begin
            cmd.crc_step = 1'b1;
            cmd.crc_sel  = 2'd0;
            step_next    = 2'd1;
            state_next   = S_CRC;
          end
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        cmd.crc_sel  = step;
        step_next    = step + 2'd1;
        if (step == 2'd3) state_next = S_IDLE;
      end
      S_ML: begin
        cmd.latch_ml = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_off   = 5'd1;
        j_next       = 5'd0;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        if (j < stat.ml) begin
          cmd.scan_chk = 1'b1;
          if (j + 5'd1 < stat.ml) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_off = j + 5'd2;
            j_next     = j + 5'd1;
          end else begin
            state_next = S_DECIDE;
          end
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_HDR;
      end
      S_HDR: begin
        if (stat.out_free) begin
          cmd.load_hdr = 1'b1;
          if (stat.single || stat.ml == 5'd0) begin
            state_next = S_END;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_off = 5'd1;
            j_next     = 5'd0;
            state_next = S_TRL;
          end
        end
      end
      S_TRL: begin
        if (stat.out_free) begin
          cmd.load_trl = 1'b1;
          cmd.trl_last = (j + 5'd1 == stat.ml);
          if (j + 5'd1 == stat.ml) begin
            state_next = S_END;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_off = j + 5'd2;
            j_next     = j + 5'd1;
          end
        end
      end
      S_END: begin
        cmd.end_frag = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 2'd0;
      j     <= 5'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
      j     <= j_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rfc_dpath.sv -----
// Datapath: header capture, CRC, test pattern LFSR, trailer ring memory,
// final checks and output record register. Depends on rfc_pkg.
`default_nettype none
module rfc_dpath
  import rfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] in_word,
  input  wire logic [7:0]  fiber_exp,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [79:0]      out_data,
  output logic             out_last
);

  logic [11:0] word_index;
  logic [31:0] crc_accum;
  logic [31:0] w_hold;
  logic [11:0] token_lo;
  logic [15:0] command_lo;
  logic        stat_flags;
  logic [7:0]  det_id;
  logic [7:0]  fiber_id;
  logic [31:0] crossing_word;
  logic        header_fail;
  logic [31:0] pattern_seed;
  logic [31:0] pattern_next;
  logic [11:0] mismatch_count;

  logic [31:0] ring [TRAILER_DEPTH];
  logic [31:0] rdata;
  logic        rvalid;
  logic [4:0]  ml;
  logic        soft_trl;
  logic        soft_fifo;

  logic        f_null, f_crit, f_soft;
  logic [12:0] f_tok;
  logic [11:0] f_pm;

  // ring read position relative to the last word; negative reads as zero
  logic [12:0] rd_pos;
  logic [31:0] rword;
  assign rd_pos = {1'b0, word_index} - 13'd1 - {8'd0, cmd.rd_off};
  assign rword  = rvalid ? rdata : 32'd0;

  logic [7:0] crc_byte;
  always_comb begin
    case (cmd.crc_sel)
      2'd0:    crc_byte = in_word[31:24];
      2'd1:    crc_byte = w_hold[23:16];
      2'd2:    crc_byte = w_hold[15:8];
      2'd3:    crc_byte = w_hold[7:0];
      default: crc_byte = 8'd0;
    endcase
  end

  // final checks
  logic [12:0] n_words;
  logic        crit_base, soft_base, idm, crit_r, soft_r, commit;
  logic [3:0]  trg, daq;
  logic [12:0] tok_r;
  assign n_words = {1'b0, word_index} + 13'd1;
  assign trg     = command_lo[7:4];
  assign daq     = command_lo[3:0];
  assign idm     = (fiber_exp != FIBER_ANY) && (fiber_exp != fiber_id);

  always_comb begin
    crit_base = (n_words < 13'(MIN_WORDS)) || (n_words > 13'(MAX_WORDS)) || header_fail ||
                (word_index < IDX_FILLER) || (det_id != DET_ID_EXP);
    soft_base = stat_flags;
    crit_r    = crit_base || ((w_hold != 32'd0) && (crc_accum != w_hold));
    soft_r    = soft_base || soft_trl || soft_fifo || (token_lo == 12'd0);
    tok_r     = (token_lo == 12'd0) ? SANE_TOKEN : {1'b0, token_lo};
    case (trg)
      TRG_CLEAR: begin
        tok_r  = SANE_TOKEN;
        crit_r = 1'b0;
        soft_r = 1'b0;
      end
      TRG_PHYS_A, TRG_PHYS_B, TRG_PATTERN, TRG_PHYS_C: ;
      default: begin
        tok_r  = SANE_TOKEN;
        soft_r = 1'b1;
      end
    endcase
    commit = (command_lo[15:8] != NULL_FORMAT) && !crit_r && !soft_r && (trg == TRG_PATTERN);
  end

  assign stat = '{ml: ml, single: (f_null || f_crit), out_free: (!out_valid || out_ready)};

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.accept) ring[word_index[RING_AW-1:0]] <= in_word;
    if (cmd.rd_en) rdata <= ring[rd_pos[RING_AW-1:0]];
  end

  logic [11:0] ml_raw;
  assign ml_raw = rword[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index     <= 12'd0;
      crc_accum      <= CRC_INIT;
      token_lo       <= 12'd0;
      command_lo     <= 16'd0;
      stat_flags     <= 1'b0;
      det_id         <= 8'd0;
      fiber_id       <= 8'd0;
      crossing_word  <= 32'd0;
      header_fail    <= 1'b0;
      pattern_seed   <= 32'd0;
      pattern_next   <= 32'd0;
      mismatch_count <= 12'd0;
      ml             <= 5'd0;
      soft_trl       <= 1'b0;
      soft_fifo      <= 1'b0;
      rvalid         <= 1'b0;
      f_null         <= 1'b0;
      f_crit         <= 1'b0;
      f_soft         <= 1'b0;
      f_tok          <= 13'd0;
      f_pm           <= 12'd0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.rd_en) rvalid <= !rd_pos[12];
      if (cmd.accept) begin
        w_hold <= in_word;
        case (word_index)
          POS_TOKEN:  token_lo <= in_word[11:0];
          POS_SIG:    if (in_word != SIG_WORD) header_fail <= 1'b1;
          POS_CMD:    command_lo <= in_word[15:0];
          POS_STAT: begin
            stat_flags <= (in_word[31:16] != 16'd0);
            det_id     <= in_word[15:8];
            fiber_id   <= in_word[7:0];
          end
          POS_XING:   crossing_word <= in_word;
          IDX_FILLER: if (in_word != FILLER_WORD) header_fail <= 1'b1;
          default: ;
        endcase
        if (word_index >= PATTERN_FIRST && word_index < PATTERN_END) begin
          if (in_word != pattern_next && mismatch_count != IDX_MAX)
            mismatch_count <= mismatch_count + 12'd1;
          pattern_next <= lfsr_next(pattern_next);
        end
        if (cmd.crc_step && word_index != IDX_MAX) word_index <= word_index + 12'd1;
      end
      if (cmd.crc_step) crc_accum <= crc_fold8(crc_accum, crc_byte);
      if (cmd.latch_ml) begin
        if (ml_raw > 12'(MAX_TRAILER_TRIGGERS)) begin
          ml       <= 5'd0;
          soft_trl <= 1'b1;
        end else begin
          ml <= ml_raw[4:0];
        end
      end
      if (cmd.scan_chk && rword[31]) soft_fifo <= 1'b1;
      if (cmd.decide) begin
        f_null <= (command_lo[15:8] == NULL_FORMAT);
        f_crit <= (command_lo[15:8] != NULL_FORMAT) && crit_r;
        f_soft <= (command_lo[15:8] == NULL_FORMAT) ? soft_base : soft_r;
        f_tok  <= tok_r;
        f_pm   <= commit ? mismatch_count : 12'd0;
        if (commit) pattern_seed <= pattern_next;
      end
      // output record register
      if (cmd.load_hdr || cmd.load_trl) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load_hdr) begin
        if (f_null) begin
          out_data <= {6'd0, 1'b1, 12'd0, idm, soft_base, crit_base, 5'd1,
                       crossing_word, 4'd0, 4'd0, SANE_TOKEN};
          out_last <= 1'b1;
        end else if (f_crit) begin
          out_data <= {6'd0, 1'b0, 12'd0, idm, f_soft, 1'b1, 5'd0,
                       32'd0, 4'd0, 4'd0, SANE_TOKEN};
          out_last <= 1'b1;
        end else begin
          out_data <= {6'd0, 1'b0, f_pm, idm, f_soft, 1'b0, ml + 5'd1,
                       crossing_word, daq, trg, f_tok};
          out_last <= (ml == 5'd0);
        end
      end
      if (cmd.load_trl) begin
        out_data  <= {6'd0, 1'b0, f_pm, idm, f_soft, 1'b0, ml + 5'd1,
                      21'd0, rword[30:20], rword[3:0], rword[7:4], 1'b0, rword[19:8]};
        out_last  <= cmd.trl_last;
      end
      if (cmd.end_frag) begin
        word_index     <= 12'd0;
        crc_accum      <= CRC_INIT;
        token_lo       <= 12'd0;
        command_lo     <= 16'd0;
        stat_flags     <= 1'b0;
        det_id         <= 8'd0;
        fiber_id       <= 8'd0;
        crossing_word  <= 32'd0;
        header_fail    <= 1'b0;
        pattern_next   <= pattern_seed;
        mismatch_count <= 12'd0;
        ml             <= 5'd0;
        soft_trl       <= 1'b0;
        soft_fifo      <= 1'b0;
        f_null         <= 1'b0;
        f_crit         <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/readout_fragment_checker_core.sv -----
// Readout fragment checker: top level with APB register and stream ports.
// Depends on rfc_pkg, rfc_ctrl, rfc_dpath.
//
// Usage: fragment words enter on s_* one transfer at a time; s_tlast marks
// the final (CRC) word. The CRC unit folds one byte per cycle; after each
// word before the last, intake waits until all four of its bytes are folded.
// The last word starts the check: a ring read of the trailer length, a scan
// of each trailer word for the FIFO limit bit, a decision step, then the
// records go out on m_* one per cycle while m_tready is high (header record
// first, then up to 30 trailer records, m_tlast on the final one), and a
// clear of fragment state. The trailer ring is a 32-entry memory with one
// read and one write port. A stalled m_tready holds the pending record in
// the output register and pauses emission; intake resumes after the final
// record is loaded into the output register and the state clear step has run.
// Synchronous reset returns the checker to idle, sets expected_fiber_id to
// 255 and clears the pattern seed; the ring needs no clearing pass.
// Register expected_fiber_id sits at byte address 0.
`default_nettype none
module readout_fragment_checker_core
  import rfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // data_word[31:0]
  input  wire logic        s_tlast,   // is_last_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // token[12:0] trg_cmd[16:13] daq_cmd[20:17] rhic_count[52:21]
  // trigger_count[57:53] critical_error[58] soft_error[59] id_mismatch[60]
  // pattern_mismatches[72:61] null_event[73] zero[79:74]
  output logic [79:0]      m_tdata,
  output logic             m_tlast    // last_of_run
);

  logic [7:0] fiber_exp;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, fiber_exp} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) fiber_exp <= FIBER_ANY;
    else if (psel && penable && pwrite && paddr[2] == 1'b0) fiber_exp <= pwdata[7:0];
  end

  rfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rfc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (s_tdata),
    .fiber_exp (fiber_exp),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire
